// ===== src/rfs_pkg.sv =====
// rfs_pkg: word types, result kind codes, register indexes and reset values
// for the radio frame splitter; no dependencies
`default_nettype none

package rfs_pkg;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_OK      = 3'd1;
  localparam logic [2:0] KIND_EMPTY   = 3'd2;
  localparam logic [2:0] KIND_SHORT   = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_ID        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 2'd2;

  // register reset values
  localparam logic [7:0] OWN_ID_RESET        = 8'h0a;
  localparam logic [7:0] HEADER_FIRST_RESET  = 8'h9f;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'he4;

  // most results one byte can cause
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned RES_CNT_W   = 3;

  localparam int unsigned PORT_MASK_W = 16;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_read;
  } item_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [7:0]             data_byte;
    logic [7:0]             sender_id;
    logic [7:0]             frame_length;
    logic [PORT_MASK_W-1:0] connected_mask;
    logic                   last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/radio_frame_splitter_core.sv =====
// radio_frame_splitter_core: splits received serial bytes into radio frames
// and emits payload words, frame status words and a read-done word
// depends on rfs_pkg
//
// latency: first result of a byte is shown the cycle after the byte is taken
// throughput: one byte per cycle while unstalled and each byte causes at most
//   one result; a byte causing more (up to 5) holds the input until its last
//   word goes, as the result buffer drains one word per unstalled cycle and refills
// reset: synchronous, clears the window, frame state and result buffer,
//   registers return to own id 0x0a and header 0x9f 0xe4
`default_nettype none

module radio_frame_splitter_core #(
  parameter int unsigned PAYLOAD_OFFSET = 8,
  parameter int unsigned MASK_BITS      = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire rfs_pkg::item_t                    item,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output rfs_pkg::result_t                       result,
  input  wire logic                              cfg_write,
  input  wire logic [rfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [rfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [7:0] PAYLOAD_POS = 8'(PAYLOAD_OFFSET);
  localparam logic [rfs_pkg::RES_CNT_W-1:0] RES_ONE = rfs_pkg::RES_CNT_W'(1);

  typedef struct packed {
    logic       in_frame;
    logic [7:0] pos;
    logic [7:0] sender;
  } frame_t;

  // one-hot bit of a sender id, zero when the id is past the mask
  function automatic logic [MASK_BITS-1:0] id_bit(input logic [7:0] id);
    logic [MASK_BITS-1:0] one;
    one = MASK_BITS'(1);
    return one << id;
  endfunction

  // mask as seen on the port, zero-filled or cut to the port width
  function automatic logic [rfs_pkg::PORT_MASK_W-1:0] port_mask(
      input logic [MASK_BITS-1:0] m);
    logic [MASK_BITS+rfs_pkg::PORT_MASK_W-1:0] ext;
    ext = {{rfs_pkg::PORT_MASK_W{1'b0}}, m};
    return ext[rfs_pkg::PORT_MASK_W-1:0];
  endfunction

  function automatic logic commit_emits(input frame_t f);
    return f.in_frame && (f.pos >= PAYLOAD_POS);
  endfunction

  function automatic frame_t commit_state(input frame_t f, input logic [7:0] b);
    frame_t r;
    r = f;
    if (f.in_frame) begin
      if (f.pos == 8'd3) begin
        r.sender = b;
      end
      if (f.pos != 8'hff) begin
        r.pos = f.pos + 8'd1;
      end
    end
    return r;
  endfunction

  function automatic rfs_pkg::result_t payload_word(input logic [7:0] b,
                                                    input logic [7:0] sender);
    rfs_pkg::result_t r;
    r = '0;
    r.kind      = rfs_pkg::KIND_PAYLOAD;
    r.data_byte = b;
    r.sender_id = sender;
    return r;
  endfunction

  function automatic rfs_pkg::result_t status_word(input frame_t f);
    rfs_pkg::result_t r;
    r = '0;
    priority if (f.pos > PAYLOAD_POS) begin
      r.kind = rfs_pkg::KIND_OK;
    end else if (f.pos == PAYLOAD_POS) begin
      r.kind = rfs_pkg::KIND_EMPTY;
    end else begin
      r.kind = rfs_pkg::KIND_SHORT;
    end
    r.sender_id    = f.sender;
    r.frame_length = f.pos;
    return r;
  endfunction

  // configuration registers
  logic [7:0] own_id;
  logic [7:0] header_first;
  logic [7:0] header_second;

  // framing state
  logic [7:0]           byte_window [2];
  logic [1:0]           window_fill;
  frame_t               frame;
  logic [MASK_BITS-1:0] seen_mask;

  // result buffer
  rfs_pkg::result_t                res_buf [rfs_pkg::MAX_RESULTS];
  logic [rfs_pkg::RES_CNT_W-1:0]   res_cnt;
  logic [rfs_pkg::RES_CNT_W-1:0]   rd_idx;

  // next values
  logic [7:0]                      byte_window_next [2];
  logic [1:0]                      window_fill_next;
  frame_t                          frame_next;
  logic [MASK_BITS-1:0]            seen_mask_next;
  rfs_pkg::result_t                res_buf_next [rfs_pkg::MAX_RESULTS];
  logic [rfs_pkg::RES_CNT_W-1:0]   res_cnt_next;

  logic item_take;
  logic header_hit;

  // handshake: take a byte once the buffer is empty or giving up its last word
  assign result_valid = (rd_idx < res_cnt);
  assign result       = res_buf[rd_idx];
  assign item_stall   = result_valid &&
                        (((rd_idx + RES_ONE) != res_cnt) || result_stall);
  assign item_take    = item_valid && !item_stall;

  assign header_hit = (window_fill == 2'd2) &&
                      (byte_window[0] == header_first) &&
                      (byte_window[1] == header_second) &&
                      (item.rx_byte == own_id);

  // one byte: window shift, commits, frame close and read end
  always_comb begin
    byte_window_next = byte_window;
    window_fill_next = window_fill;
    frame_next       = frame;
    seen_mask_next   = seen_mask;
    res_cnt_next     = '0;
    for (int i = 0; i < rfs_pkg::MAX_RESULTS; i++) begin
      res_buf_next[i] = '0;
    end

    // window step
    if (header_hit) begin
      if (frame_next.in_frame) begin
        res_buf_next[res_cnt_next] = status_word(frame_next);
        res_cnt_next = res_cnt_next + RES_ONE;
        if (frame_next.sender != 8'd0) begin
          seen_mask_next = seen_mask_next | id_bit(frame_next.sender);
        end
      end
      frame_next.in_frame = 1'b1;
      frame_next.pos      = 8'd1;
      frame_next.sender   = 8'd0;
      byte_window_next[0] = byte_window[1];
      byte_window_next[1] = item.rx_byte;
    end else if (window_fill == 2'd2) begin
      if (commit_emits(frame_next)) begin
        res_buf_next[res_cnt_next] = payload_word(byte_window[0], frame_next.sender);
        res_cnt_next = res_cnt_next + RES_ONE;
      end
      frame_next = commit_state(frame_next, byte_window[0]);
      byte_window_next[0] = byte_window[1];
      byte_window_next[1] = item.rx_byte;
    end else begin
      byte_window_next[window_fill[0]] = item.rx_byte;
      window_fill_next = window_fill + 2'd1;
    end

    // end of read: flush window, close frame, report mask, restart
    if (item.end_of_read) begin
      for (int i = 0; i < 2; i++) begin
        if (i < int'(window_fill_next)) begin
          if (commit_emits(frame_next)) begin
            res_buf_next[res_cnt_next] = payload_word(byte_window_next[i],
                                                      frame_next.sender);
            res_cnt_next = res_cnt_next + RES_ONE;
          end
          frame_next = commit_state(frame_next, byte_window_next[i]);
        end
      end
      if (frame_next.in_frame) begin
        res_buf_next[res_cnt_next] = status_word(frame_next);
        res_cnt_next = res_cnt_next + RES_ONE;
        if (frame_next.sender != 8'd0) begin
          seen_mask_next = seen_mask_next | id_bit(frame_next.sender);
        end
      end
      res_buf_next[res_cnt_next] = '0;
      res_buf_next[res_cnt_next].kind = rfs_pkg::KIND_DONE;
      res_buf_next[res_cnt_next].connected_mask = port_mask(seen_mask_next);
      res_cnt_next = res_cnt_next + RES_ONE;
      byte_window_next[0] = 8'd0;
      byte_window_next[1] = 8'd0;
      window_fill_next    = 2'd0;
      frame_next          = '0;
      seen_mask_next      = id_bit(own_id);
    end

    // flag the last word of this byte
    if (res_cnt_next != '0) begin
      res_buf_next[res_cnt_next - RES_ONE].last = 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_id        <= rfs_pkg::OWN_ID_RESET;
      header_first  <= rfs_pkg::HEADER_FIRST_RESET;
      header_second <= rfs_pkg::HEADER_SECOND_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rfs_pkg::REG_OWN_ID:        own_id        <= cfg_data;
        rfs_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data;
        rfs_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // framing state and buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window[0] <= 8'd0;
      byte_window[1] <= 8'd0;
      window_fill    <= 2'd0;
      frame          <= '0;
      seen_mask      <= id_bit(rfs_pkg::OWN_ID_RESET);
      res_cnt        <= '0;
      rd_idx         <= '0;
    end else if (item_take) begin
      byte_window <= byte_window_next;
      window_fill <= window_fill_next;
      frame       <= frame_next;
      seen_mask   <= seen_mask_next;
      res_cnt     <= res_cnt_next;
      rd_idx      <= '0;
    end else if (result_valid && !result_stall) begin
      rd_idx <= rd_idx + RES_ONE;
    end
  end

  // result words
  always_ff @(posedge clk) begin
    if (item_take) begin
      res_buf <= res_buf_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/rfs_checker.sv =====
// rfs_checker: port-level checks on the radio frame splitter result channel
// depends on rfs_pkg; bound to radio_frame_splitter_core
`default_nettype none

module rfs_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire rfs_pkg::result_t result
);

  // a stalled word stays offered
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  // a stalled word does not change
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result word changed while stalled");

  // read done always closes the words of its byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == rfs_pkg::KIND_DONE) |-> result.last)
    else $error("read done word not marked last");

  // payload words carry no length and no mask
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == rfs_pkg::KIND_PAYLOAD) |->
      (result.frame_length == 8'd0) && (result.connected_mask == '0))
    else $error("payload word with length or mask");

  // a taken word that is not last in its byte's group is followed by another word
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last |=> result_valid)
    else $error("group of result words broken off");

endmodule

bind radio_frame_splitter_core rfs_checker u_rfs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
